>>> rtl/sum_checked_frame_receiver_unit_assert.svh
// Assertion macros used by the frame receiver checker.
`ifndef SUM_CHECKED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SUM_CHECKED_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define SCFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scfr assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define SCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scfr assertion failed");

`endif

>>> rtl/scfr_pkg.sv
// Shared types and constants for the sum-checked frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned EVENT_W  = 3;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'd256;

    // Depth of the queue between the parser and the checksum stage
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_HEADER   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_PAYLOAD  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_GOOD     = 3'd2;
    localparam logic [EVENT_W-1:0] EV_BAD      = 3'd3;
    localparam logic [EVENT_W-1:0] EV_OVERSIZE = 3'd4;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CSUM
    } phase_t;

    // What the parser decided about one byte
    typedef enum logic [2:0] {
        K_CMD,
        K_HDR,
        K_PAY,
        K_CSUM,
        K_OVER
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   index;
        logic [BYTE_W-1:0]  command;
        logic [LEN_W-1:0]   length;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/scfr_front.sv
// Frame parser: tracks the frame phase and classifies each received byte.
`timescale 1ns / 1ps
`default_nettype none

module scfr_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         take,
    input  wire logic [scfr_pkg::BYTE_W-1:0]  rx_byte,
    input  wire logic                         cfg_write,
    input  wire logic [scfr_pkg::LEN_W-1:0]   cfg_data,
    output scfr_pkg::entry_t                  entry
);
    import scfr_pkg::*;

    phase_t             phase_reg,   phase_next;
    logic [LEN_W-1:0]   count_reg,   count_next;
    logic [LEN_W-1:0]   length_reg,  length_next;
    logic [BYTE_W-1:0]  command_reg, command_next;
    logic               over_reg,    over_next;
    logic [LEN_W-1:0]   max_reg;
    logic [LEN_W-1:0]   len_full;
    logic [LEN_W-1:0]   count_inc;
    kind_t              kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_CMD;
            count_reg   <= '0;
            length_reg  <= '0;
            command_reg <= '0;
            over_reg    <= 1'b0;
            max_reg     <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            if (take)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                length_reg  <= length_next;
                command_reg <= command_next;
                over_reg    <= over_next;
            end
            if (cfg_write)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        command_next = command_reg;
        over_next    = over_reg;
        kind         = K_HDR;
        len_full     = {rx_byte, length_reg[BYTE_W-1:0]};
        count_inc    = count_reg + 1'b1;

        unique case (phase_reg)
            PH_LEN_LO:
            begin
                length_next = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = len_full;
                count_next  = '0;
                over_next   = (len_full > max_reg);
                // empty payload goes straight to the checksum byte
                phase_next  = (len_full == '0) ? PH_CSUM : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                kind       = over_reg ? K_HDR : K_PAY;
                count_next = count_inc;
                if (count_inc == length_reg)
                begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                kind       = over_reg ? K_OVER : K_CSUM;
                phase_next = PH_CMD;
            end
            default:
            begin
                kind         = K_CMD;
                command_next = rx_byte;
                length_next  = '0;
                count_next   = '0;
                over_next    = 1'b0;
                phase_next   = PH_LEN_LO;
            end
        endcase
    end

    always_comb
    begin
        entry.kind    = kind;
        entry.data    = rx_byte;
        entry.index   = count_reg;
        entry.command = command_next;
        entry.length  = length_next;
    end

endmodule

`default_nettype wire

>>> rtl/scfr_queue.sv
// Short queue of classified bytes between the parser and the checksum stage.
`timescale 1ns / 1ps
`default_nettype none

module scfr_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire scfr_pkg::entry_t wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output scfr_pkg::entry_t      rd_data,
    output logic                  valid
);
    import scfr_pkg::*;

    entry_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                do_wr;
    logic                do_rd;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;
    assign rd_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/scfr_back.sv
// Checksum stage: keeps the running sum and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module scfr_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire scfr_pkg::entry_t              q_data,
    output logic                               q_rd,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [scfr_pkg::EVENT_W-1:0]       event_res,
    output logic [scfr_pkg::BYTE_W-1:0]        payload_byte,
    output logic [scfr_pkg::LEN_W-1:0]         payload_index,
    output logic [scfr_pkg::BYTE_W-1:0]        command,
    output logic [scfr_pkg::LEN_W-1:0]         frame_length
);
    import scfr_pkg::*;

    logic [BYTE_W-1:0]   sum_reg,   sum_next;
    logic                valid_reg;
    logic [EVENT_W-1:0]  event_reg, event_next;
    logic [BYTE_W-1:0]   byte_reg,  byte_next;
    logic [LEN_W-1:0]    index_reg, index_next;
    logic [BYTE_W-1:0]   cmd_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                load;

    // advance when the result register is free or being drained
    assign load = q_valid && (!valid_reg || pop);
    assign q_rd = load;

    always_comb
    begin
        sum_next   = sum_reg;
        event_next = EV_HEADER;
        byte_next  = '0;
        index_next = '0;
        case (q_data.kind)
            K_CMD:
            begin
                sum_next = '0;
            end
            K_PAY:
            begin
                event_next = EV_PAYLOAD;
                byte_next  = q_data.data;
                index_next = q_data.index;
                sum_next   = sum_reg + q_data.data;
            end
            K_CSUM:
            begin
                event_next = (q_data.data == sum_reg) ? EV_GOOD : EV_BAD;
            end
            K_OVER:
            begin
                event_next = EV_OVERSIZE;
            end
            default:
            begin
                event_next = EV_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                sum_reg   <= sum_next;
                valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            event_reg <= event_next;
            byte_reg  <= byte_next;
            index_reg <= index_next;
            cmd_reg   <= q_data.command;
            len_reg   <= q_data.length;
        end
    end

    assign empty         = !valid_reg;
    assign event_res     = event_reg;
    assign payload_byte  = byte_reg;
    assign payload_index = index_reg;
    assign command       = cmd_reg;
    assign frame_length  = len_reg;

endmodule

`default_nettype wire

>>> rtl/sum_checked_frame_receiver_unit.sv
// Top level of the sum-checked frame receiver.
// An accepted byte is written into the queue, then loaded into the result register once it is free or being popped.
// Throughput: one byte per cycle while full is low; full rises only when the two-entry queue
// behind the parser is full because results are not being popped.
// Reset: rst_n clears phase, counters, sum, queue pointers and the result valid flag at once;
// max_payload returns to 256. No clearing pass, bytes are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module sum_checked_frame_receiver_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [scfr_pkg::BYTE_W-1:0]   rx_byte,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [scfr_pkg::EVENT_W-1:0]       event_res,
    output logic [scfr_pkg::BYTE_W-1:0]        payload_byte,
    output logic [scfr_pkg::LEN_W-1:0]         payload_index,
    output logic [scfr_pkg::BYTE_W-1:0]        command,
    output logic [scfr_pkg::LEN_W-1:0]         frame_length,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [scfr_pkg::LEN_W-1:0]    cfg_data
);
    import scfr_pkg::*;

    entry_t  front_entry;
    entry_t  q_data;
    logic    q_full;
    logic    q_valid;
    logic    q_rd;
    logic    take;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign take      = push && !q_full;

    scfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx_byte),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .entry     (front_entry)
    );

    scfr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (front_entry),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .valid   (q_valid)
    );

    scfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_rd          (q_rd),
        .empty         (empty),
        .pop           (pop),
        .event_res     (event_res),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .command       (command),
        .frame_length  (frame_length)
    );

endmodule

`default_nettype wire

>>> rtl/scfr_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "sum_checked_frame_receiver_unit_assert.svh"

module scfr_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          empty,
    input  wire logic                          pop,
    input  wire logic [scfr_pkg::EVENT_W-1:0]  event_res,
    input  wire logic [scfr_pkg::BYTE_W-1:0]   payload_byte,
    input  wire logic [scfr_pkg::LEN_W-1:0]    payload_index,
    input  wire logic [scfr_pkg::LEN_W-1:0]    frame_length
);
    import scfr_pkg::*;

    // a waiting beat holds until it is popped
    `SCFR_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(event_res))

    // only payload beats carry a byte and an index
    `SCFR_ASSERT_NOW(a_zero_fields, clk, rst_n, !empty && (event_res != EV_PAYLOAD), (payload_byte == '0) && (payload_index == '0))

    // payload position stays inside the announced length
    `SCFR_ASSERT_NOW(a_index_range, clk, rst_n, !empty && (event_res == EV_PAYLOAD), payload_index < frame_length)

    // a dropped frame always announced a nonzero length
    `SCFR_ASSERT_NOW(a_drop_len, clk, rst_n, !empty && (event_res == EV_OVERSIZE), frame_length != '0)

endmodule

bind sum_checked_frame_receiver_unit scfr_checker u_scfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .event_res     (event_res),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .frame_length  (frame_length)
);

`default_nettype wire
